@@ rtl/core/xsrg_pkg.sv @@
// Shared types and constants for the xorshift128 range generator.
`default_nettype none

package xsrg_pkg;

  localparam int WORD_W  = 32;
  localparam int VALUE_W = 30;
  localparam int BOUND_W = 31;

  localparam logic [WORD_W-1:0] SEED_A = 32'd123456789;
  localparam logic [WORD_W-1:0] SEED_B = 32'd362436069;
  localparam logic [WORD_W-1:0] SEED_C = 32'd521288629;
  localparam logic [WORD_W-1:0] SEED_D = 32'd88675123;

  localparam int SHIFT_T_LEFT  = 11;
  localparam int SHIFT_D_RIGHT = 19;
  localparam int SHIFT_T_RIGHT = 8;

  // One remainder step per dividend bit.
  localparam int DIV_STEPS = VALUE_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } xsrg_state_t;

  typedef struct packed {
    logic load;      // take an input transaction, advance the generator
    logic div_step;  // one remainder step
    logic out_load;  // move the finished result into the output register
  } xsrg_cmd_t;

  typedef struct packed {
    logic ranged;    // ranged request with a non-empty range
    logic out_busy;  // output register holds a result that is not taken this cycle
  } xsrg_status_t;

endpackage

`default_nettype wire

@@ rtl/core/xsrg_ctrl.sv @@
// Controller: sequences load, remainder steps and result hand-off.
`default_nettype none

module xsrg_ctrl
  import xsrg_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire xsrg_status_t status,
  output xsrg_cmd_t         cmd
);

  xsrg_state_t      state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DIV;
          cnt_next   = CNT_LAST;
        end
      end
      ST_DIV: begin
        if (!status.ranged || cnt == '0) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = status.ranged;
      end
      ST_DONE: begin
        cmd.out_load = !status.out_busy;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/xsrg_dp.sv @@
// Datapath: xorshift128 state, serial remainder unit and output register.
`default_nettype none

module xsrg_dp
  import xsrg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire xsrg_cmd_t          cmd,
  output xsrg_status_t            status,
  input  wire logic               req_type,
  input  wire logic [BOUND_W-1:0] lower_bound,
  input  wire logic [BOUND_W-1:0] upper_bound,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [BOUND_W-1:0]      random_value,
  output logic                    range_error
);

  logic [WORD_W-1:0]  word_a, word_b, word_c, word_d;
  logic [WORD_W-1:0]  t_mix, d_next;
  logic [VALUE_W-1:0] value;     // shifts out MSB-first during division
  logic [VALUE_W-1:0] raw_value; // kept for raw mode
  logic [BOUND_W-1:0] lower, span, rem;
  logic               ranged, err;
  logic               range_ok;
  logic [BOUND_W:0]   trial, trial_diff;
  logic [BOUND_W-1:0] result;

  assign t_mix  = word_a ^ (word_a << SHIFT_T_LEFT);
  assign d_next = (word_d ^ (word_d >> SHIFT_D_RIGHT)) ^ (t_mix ^ (t_mix >> SHIFT_T_RIGHT));

  assign range_ok = upper_bound > lower_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_a <= SEED_A;
      word_b <= SEED_B;
      word_c <= SEED_C;
      word_d <= SEED_D;
    end else if (cmd.load) begin
      word_a <= word_b;
      word_b <= word_c;
      word_c <= word_d;
      word_d <= d_next;
    end
  end

  // Restoring remainder: shift in one dividend bit, subtract span if it fits.
  assign trial      = {rem, value[VALUE_W-1]};
  assign trial_diff = trial - {1'b0, span};

  always_ff @(posedge clk) begin
    if (rst) begin
      ranged <= 1'b0;
      err    <= 1'b0;
    end else if (cmd.load) begin
      ranged <= req_type & range_ok;
      err    <= req_type & ~range_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value     <= d_next[VALUE_W-1:0];
      raw_value <= d_next[VALUE_W-1:0];
      lower     <= lower_bound;
      span      <= upper_bound - lower_bound;
      rem       <= '0;
    end else if (cmd.div_step) begin
      value <= {value[VALUE_W-2:0], 1'b0};
      if (trial >= {1'b0, span}) begin
        rem <= trial_diff[BOUND_W-1:0];
      end else begin
        rem <= trial[BOUND_W-1:0];
      end
    end
  end

  always_comb begin
    priority if (ranged) begin
      result = lower + rem;
    end else if (err) begin
      result = '0;
    end else begin
      result = BOUND_W'(raw_value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      random_value <= result;
      range_error  <= err;
    end
  end

  assign status.ranged   = ranged;
  assign status.out_busy = out_valid & ~out_ready;

endmodule

`default_nettype wire

@@ rtl/core/xorshift128_range_generator.sv @@
// Top level of the xorshift128 range generator.
//
// Input stream s_axis: one transaction is one request. tuser selects raw
// (0) or ranged (1) mode; tdata carries the lower and upper bounds.
// Output stream m_axis: one transaction per request, in request order.
// tdata carries the value, tuser the range error flag.
// Every request advances the xorshift128 state once at acceptance.
// Raw requests and empty/inverted ranges: after acceptance the controller
// passes through ST_DIV and ST_DONE, and m_axis_tvalid is registered on the
// ST_DONE hand-off. Ranged requests: the remainder unit takes one bit per
// cycle over the 30 value bits in ST_DIV before ST_DONE. s_axis_tready is
// high only in ST_IDLE, so no request is taken while one is in progress.
// The output register frees the datapath: a finished result waits there
// while the next request is accepted; if the receiver still stalls when the
// following result is ready, the block holds it and deasserts s_axis_tready.
// Reset (rst, synchronous) reloads the fixed seeds and empties the output.
`default_nettype none

module xorshift128_range_generator
  import xsrg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [30:0] lower_bound, [61:31] upper_bound
  input  wire logic                  s_axis_tuser,  // [0] req_type
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [30:0] random_value
  output logic                       m_axis_tuser   // [0] range_error
);

  xsrg_cmd_t          cmd;
  xsrg_status_t       status;
  logic [BOUND_W-1:0] random_value;

  xsrg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  xsrg_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .req_type     (s_axis_tuser),
    .lower_bound  (s_axis_tdata[BOUND_W-1:0]),
    .upper_bound  (s_axis_tdata[2*BOUND_W-1:BOUND_W]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .random_value (random_value),
    .range_error  (m_axis_tuser)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-BOUND_W){1'b0}}, random_value};

endmodule

`default_nettype wire
